// ----- hdl/cgf_pkg.sv -----
// cgf_pkg: shared types and constants of the 3x3 grey convolution filter.
// No dependencies; imported by every module of the block except cgf_ram.
package cgf_pkg;

  localparam int PIX_W      = 8;
  localparam int COEF_W     = 16;
  localparam int COEF_ROW_W = 3 * COEF_W;
  localparam int RW         = 12;    // row counter
  localparam int HW         = 13;    // image_height register / effective height
  localparam int MAX_HEIGHT = 4096;
  localparam int CFG_IDX_W  = 3;
  localparam int Q_DEPTH    = 8;     // result queue entries, also the credit limit
  localparam int QAW        = $clog2(Q_DEPTH);
  localparam int QCW        = $clog2(Q_DEPTH + 1);

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_DRAIN = 1'b1
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH    = 3'd0,
    CFG_HEIGHT   = 3'd1,
    CFG_COEF_TOP = 3'd2,
    CFG_COEF_MID = 3'd3,
    CFG_COEF_BOT = 3'd4
  } cfg_reg_t;

  typedef logic [2:0][2:0][PIX_W-1:0] win_t;     // [row][column]
  typedef logic [2:0][COEF_ROW_W-1:0] coef_t;    // top, middle, bottom

  // Accepted item on its way to the line stores
  typedef struct packed {
    logic             valid;
    logic             pix;       // pixel (writes the line stores, shifts the window)
    logic             emit;      // gives a result
    logic             interior;  // result is filtered
    logic             fin;       // final pixel of the image
    logic             sel_mid;   // drain reads the middle store
    logic [PIX_W-1:0] px;
  } cmd_t;

  // Result on its way through the MAC pipeline
  typedef struct packed {
    logic             valid;
    logic             interior;
    logic             fin;
    logic [PIX_W-1:0] pass;
  } res_t;

  typedef struct packed {
    logic             valid;
    logic [PIX_W-1:0] pixel;
    logic             last;
  } push_t;

  typedef struct packed {
    logic q_full;
    logic q_empty;
    logic cred_zero;
    logic cred_full;
  } qstat_t;

endpackage

// ----- hdl/conv3x3_gray_filter.sv -----
// conv3x3_gray_filter: top level of the streaming 3x3 grey convolution filter.
// Depends on cgf_pkg, cgf_seq, cgf_lines, cgf_mac, cgf_outq (and cgf_ram).
//
//  channel | signals                                  | direction
//  --------+------------------------------------------+----------
//  in      | in_valid, in_ready, op, pixel_in         | sink
//  out     | out_valid, out_ready, pixel_out, last    | source
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data| sink
//
// One input transaction per clock sustained while a credit is free; the line
// stores are read at acceptance and written back in the next cycle, so
// throughput is set by that single read-modify-write slot per cycle. A result
// passes the cmd, res, s2 and s3 registers before it enters the queue. Up to
// 8 results may be in flight or queued; in_ready drops when all 8 credits are
// held, so a stalled output backs up into the input only after that. Synchronous
// reset clears positions, window, pipeline valids and the queue; line store
// contents are not cleared and no clearing pass is run. in_ready and cfg_ready
// are held low during reset; outside reset cfg_ready is always high.
module conv3x3_gray_filter #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           op,
  input  logic [cgf_pkg::PIX_W-1:0]      pixel_in,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [cgf_pkg::PIX_W-1:0]      pixel_out,
  output logic                           last,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [cgf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cgf_pkg::COEF_ROW_W-1:0] cfg_data
);
  import cgf_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int CW = $clog2(MAX_WIDTH + 1);

  // configuration registers
  logic [11:0]   image_width;
  logic [HW-1:0] image_height;
  coef_t         coef_rows;

  logic          cfg_acc, restart, acc, take, rd_en;
  logic [CW-1:0] eff_w;
  logic [HW-1:0] eff_h;
  logic [AW-1:0] rd_addr, cmd_addr;
  cmd_t          cmd;
  win_t          win;
  res_t          res;
  push_t         push;
  qstat_t        q_stat;

  assign cfg_ready = !rst;
  assign cfg_acc   = cfg_valid && cfg_ready;
  // a geometry write restarts the stream
  assign restart   = cfg_acc && ((cfg_index == CFG_WIDTH) || (cfg_index == CFG_HEIGHT));

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= 12'd512;
      image_height <= 13'd512;
      coef_rows[0] <= '0;
      coef_rows[1] <= 48'h0000_0100_0000;    // identity: centre tap 1.0
      coef_rows[2] <= '0;
    end else if (cfg_acc) begin
      case (cfg_index)
        CFG_WIDTH:    image_width  <= cfg_data[11:0];
        CFG_HEIGHT:   image_height <= cfg_data[HW-1:0];
        CFG_COEF_TOP: coef_rows[0] <= cfg_data;
        CFG_COEF_MID: coef_rows[1] <= cfg_data;
        CFG_COEF_BOT: coef_rows[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // effective geometry: zero counts as one, oversize clamps to the maximum
  always_comb begin
    if (image_width == '0) begin
      eff_w = CW'(1);
    end else if (32'(image_width) > MAX_WIDTH) begin
      eff_w = CW'(MAX_WIDTH);
    end else begin
      eff_w = CW'(image_width);
    end
    if (image_height == '0) begin
      eff_h = HW'(1);
    end else if (32'(image_height) > MAX_HEIGHT) begin
      eff_h = HW'(MAX_HEIGHT);
    end else begin
      eff_h = image_height;
    end
  end

  // acceptance is credit-based, independent of out_ready in the same cycle
  assign in_ready = !rst && !q_stat.cred_full;
  assign acc      = in_valid && in_ready;

  cgf_seq #(.MAX_WIDTH(MAX_WIDTH)) u_seq (
    .clk      (clk),
    .rst      (rst),
    .acc      (acc),
    .op       (op),
    .pixel_in (pixel_in),
    .restart  (restart),
    .eff_w    (eff_w),
    .eff_h    (eff_h),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .take     (take),
    .cmd      (cmd),
    .cmd_addr (cmd_addr)
  );

  // line stores: read at accept, modify and write back in the next cycle
  cgf_lines #(.MAX_WIDTH(MAX_WIDTH)) u_lines (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .cmd      (cmd),
    .cmd_addr (cmd_addr),
    .win      (win),
    .res      (res)
  );

  cgf_mac u_mac (
    .clk    (clk),
    .rst    (rst),
    .res_in (res),
    .win    (win),
    .coef   (coef_rows),
    .push   (push)
  );

  cgf_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .take      (take),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .pixel_out (pixel_out),
    .last      (last),
    .stat      (q_stat)
  );

  // line store work only follows an accepted input transaction
  a_cmd_follows_accept: assert property (@(posedge clk) disable iff (rst)
    cmd.valid |-> $past(in_valid && in_ready))
    else $error("line store command without input transaction");

  // credits must keep the queue from overflowing
  a_no_queue_overflow: assert property (@(posedge clk) disable iff (rst)
    push.valid |-> !q_stat.q_full)
    else $error("result pushed into a full queue");

  // every queued result holds a credit
  a_queue_credit: assert property (@(posedge clk) disable iff (rst)
    !q_stat.q_empty |-> !q_stat.cred_zero)
    else $error("queued result without credit");

endmodule

// ----- hdl/cgf_ram.sv -----
// cgf_ram: generic single-port-write, single-port-read RAM, registered read.
// Read-first on a same-address collision. No dependencies.
module cgf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- hdl/cgf_seq.sv -----
// cgf_seq: input/output raster positions, pending count and result decision.
// Issues the line store read at acceptance. Depends on cgf_pkg.
module cgf_seq #(
  parameter int MAX_WIDTH = 2048,
  localparam int AW = $clog2(MAX_WIDTH),
  localparam int CW = $clog2(MAX_WIDTH + 1),
  localparam int PW = $clog2(MAX_WIDTH + 3)
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     acc,
  input  logic                     op,
  input  logic [cgf_pkg::PIX_W-1:0] pixel_in,
  input  logic                     restart,
  input  logic [CW-1:0]            eff_w,
  input  logic [cgf_pkg::HW-1:0]   eff_h,
  output logic                     rd_en,
  output logic [AW-1:0]            rd_addr,
  output logic                     take,
  output cgf_pkg::cmd_t            cmd,
  output logic [AW-1:0]            cmd_addr
);
  import cgf_pkg::*;

  logic [AW-1:0] in_col, out_col;
  logic [RW-1:0] in_row, out_row;
  logic [PW-1:0] pending;

  logic [CW-1:0] col_inc, ocol_inc;
  logic [HW-1:0] row_inc, orow_inc;
  logic [PW-1:0] pend_inc;
  logic          in_col_end, in_row_end, o_col_end, o_row_end;
  logic          px_emit, do_pix, do_drain, emit, interior;

  always_comb begin
    col_inc    = CW'(in_col) + CW'(1);
    in_col_end = col_inc >= eff_w;
    row_inc    = HW'(in_row) + HW'(1);
    in_row_end = row_inc >= eff_h;
    ocol_inc   = CW'(out_col) + CW'(1);
    o_col_end  = ocol_inc >= eff_w;
    orow_inc   = HW'(out_row) + HW'(1);
    o_row_end  = orow_inc >= eff_h;
    pend_inc   = pending + PW'(1);
    px_emit    = pend_inc > (PW'(eff_w) + PW'(1));

    do_pix   = acc && (op == OP_PIXEL);
    // drain only once the image is complete and something is pending
    do_drain = acc && (op == OP_DRAIN) && (pending != '0) &&
               (in_col == '0) && (in_row == '0);
    emit     = (do_pix && px_emit) || do_drain;
    interior = do_pix && (out_row != '0) && !o_row_end &&
               (out_col != '0) && !o_col_end;

    rd_en   = do_pix || do_drain;
    rd_addr = do_pix ? in_col : out_col;
    take    = emit;
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      in_col  <= '0;
      in_row  <= '0;
      out_col <= '0;
      out_row <= '0;
      pending <= '0;
    end else begin
      if (do_pix) begin
        in_col <= in_col_end ? '0 : col_inc[AW-1:0];
        if (in_col_end) begin
          in_row <= in_row_end ? '0 : row_inc[RW-1:0];
        end
        if (!px_emit) begin
          pending <= pend_inc;
        end
      end else if (do_drain) begin
        pending <= pending - PW'(1);
      end
      if (emit) begin
        out_col <= o_col_end ? '0 : ocol_inc[AW-1:0];
        if (o_col_end) begin
          out_row <= o_row_end ? '0 : orow_inc[RW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd.valid <= 1'b0;
    end else begin
      cmd.valid    <= rd_en;
      cmd.pix      <= do_pix;
      cmd.emit     <= emit;
      cmd.interior <= interior;
      cmd.fin      <= o_row_end && o_col_end;
      cmd.sel_mid  <= o_row_end;
      cmd.px       <= pixel_in;
      cmd_addr     <= rd_addr;
    end
  end

endmodule

// ----- hdl/cgf_lines.sv -----
// cgf_lines: the two line stores, write-back forwarding and the 3x3 window.
// Depends on cgf_pkg and cgf_ram.
module cgf_lines #(
  parameter int MAX_WIDTH = 2048,
  localparam int AW = $clog2(MAX_WIDTH)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  input  cgf_pkg::cmd_t cmd,
  input  logic [AW-1:0] cmd_addr,
  output cgf_pkg::win_t win,
  output cgf_pkg::res_t res
);
  import cgf_pkg::*;

  logic [PIX_W-1:0] up_raw, mid_raw, up_q, mid_q;
  logic             wr_en, hit;

  // last write-back, covers the read issued in the same cycle as that write
  logic             fwd_valid;
  logic [AW-1:0]    fwd_addr;
  logic [PIX_W-1:0] fwd_up, fwd_mid;

  assign wr_en = cmd.valid && cmd.pix;
  assign hit   = fwd_valid && (fwd_addr == cmd_addr);
  assign up_q  = hit ? fwd_up : up_raw;
  assign mid_q = hit ? fwd_mid : mid_raw;

  cgf_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_upper (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (cmd_addr),
    .wr_data (mid_q),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (up_raw)
  );

  cgf_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_middle (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (cmd_addr),
    .wr_data (cmd.px),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (mid_raw)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
      win       <= '0;
      res.valid <= 1'b0;
    end else begin
      if (wr_en) begin
        fwd_valid <= 1'b1;
        fwd_addr  <= cmd_addr;
        fwd_up    <= mid_q;
        fwd_mid   <= cmd.px;
        for (int r = 0; r < 3; r++) begin
          win[r][0] <= win[r][1];
          win[r][1] <= win[r][2];
        end
        win[0][2] <= up_q;
        win[1][2] <= mid_q;
        win[2][2] <= cmd.px;
      end
      res.valid    <= cmd.valid && cmd.emit;
      res.interior <= cmd.interior;
      res.fin      <= cmd.fin;
      // new window centre on a pixel, raw line store on a drain
      res.pass     <= cmd.pix ? win[1][2] : (cmd.sel_mid ? mid_q : up_q);
    end
  end

endmodule

// ----- hdl/cgf_mac.sv -----
// cgf_mac: nine registered products, row sums, rounding and clamp.
// Depends on cgf_pkg.
module cgf_mac (
  input  logic           clk,
  input  logic           rst,
  input  cgf_pkg::res_t  res_in,
  input  cgf_pkg::win_t  win,
  input  cgf_pkg::coef_t coef,
  output cgf_pkg::push_t push
);
  import cgf_pkg::*;

  localparam int PRW = PIX_W + 1 + COEF_W;   // 25
  localparam int RSW = PRW + 2;              // 27
  localparam int TW  = RSW + 2;              // 29

  logic signed [PRW-1:0] prod [3][3];
  logic signed [RSW-1:0] rsum [3];
  res_t                  s2, s3;

  logic signed [TW-1:0]     total;
  logic signed [TW-9:0]     shifted;
  logic        [PIX_W-1:0]  filt;

  always_ff @(posedge clk) begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        prod[r][c] <= $signed({1'b0, win[r][c]}) *
                      $signed(coef[r][COEF_W*c +: COEF_W]);
      end
      rsum[r] <= RSW'(prod[r][0]) + RSW'(prod[r][1]) + RSW'(prod[r][2]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2.valid <= 1'b0;
      s3.valid <= 1'b0;
    end else begin
      s2 <= res_in;
      s3 <= s2;
    end
  end

  // half up: add 0.5 in Q8.8, floor, clamp to 0..255
  always_comb begin
    total   = TW'(rsum[0]) + TW'(rsum[1]) + TW'(rsum[2]) + TW'(128);
    shifted = total[TW-1:8];
    if (total < 0) begin
      filt = '0;
    end else if (shifted > 255) begin
      filt = 8'd255;
    end else begin
      filt = shifted[PIX_W-1:0];
    end
    push.valid = s3.valid;
    push.pixel = s3.interior ? filt : s3.pass;
    push.last  = s3.fin;
  end

endmodule

// ----- hdl/cgf_outq.sv -----
// cgf_outq: result queue and credit count that throttles input acceptance.
// Depends on cgf_pkg.
module cgf_outq (
  input  logic                      clk,
  input  logic                      rst,
  input  cgf_pkg::push_t            push,
  input  logic                      take,
  input  logic                      out_ready,
  output logic                      out_valid,
  output logic [cgf_pkg::PIX_W-1:0] pixel_out,
  output logic                      last,
  output cgf_pkg::qstat_t           stat
);
  import cgf_pkg::*;

  logic [PIX_W:0]   q [Q_DEPTH];
  logic [QAW-1:0]   wr_ptr, rd_ptr;
  logic [QCW-1:0]   fill, credits;
  logic             pop;

  assign out_valid = (fill != '0);
  assign pop       = out_valid && out_ready;
  assign pixel_out = q[rd_ptr][PIX_W:1];
  assign last      = q[rd_ptr][0];

  assign stat.q_full    = (fill == QCW'(Q_DEPTH));
  assign stat.q_empty   = (fill == '0);
  assign stat.cred_zero = (credits == '0);
  assign stat.cred_full = (credits == QCW'(Q_DEPTH));

  always_ff @(posedge clk) begin
    if (push.valid) begin
      q[wr_ptr] <= {push.pixel, push.last};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      fill    <= '0;
      credits <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr <= wr_ptr + QAW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QAW'(1);
      end
      if (push.valid && !pop) begin
        fill <= fill + QCW'(1);
      end else if (!push.valid && pop) begin
        fill <= fill - QCW'(1);
      end
      if (take && !pop) begin
        credits <= credits + QCW'(1);
      end else if (!take && pop) begin
        credits <= credits - QCW'(1);
      end
    end
  end

endmodule
